// File: rtl/core/lps_pkg.sv
// shared types, constants and register codes for the loop playback block
package lps_pkg;

    localparam int LEN_W       = 17;
    localparam int SPEED_W     = 16;
    localparam int XFADE_W     = 8;
    localparam int SAMPLE_W    = 16;
    localparam int CMD_W       = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 17;

    localparam int DEF_MAX_LEN  = 65536;
    localparam int DEF_CHANNELS = 2;

    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEEK  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_LOOP_LENGTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLAYING       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CROSSFADE_LEN = 3'd4;

    localparam logic [LEN_W-1:0]   RST_LOOP_LENGTH = 17'd65536;
    localparam logic [SPEED_W-1:0] RST_SPEED       = 16'd4096;
    localparam logic [XFADE_W-1:0] RST_XFADE_LEN   = 8'd64;

    localparam logic [SPEED_W-1:0] SPEED_MAX = 16'd32768;
    localparam logic [XFADE_W-1:0] XFADE_MIN = 8'd16;
    localparam logic [XFADE_W-1:0] XFADE_MAX = 8'd128;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEEK_GO,
        ST_SEEK_WAIT,
        ST_SEEK_SET,
        ST_RD_DST,
        ST_RD_SRC,
        ST_SRC_LAT,
        ST_T_WAIT,
        ST_MUL_L,
        ST_MUL_R,
        ST_MIX_R,
        ST_INC_GO,
        ST_INC_WAIT,
        ST_POS_GO,
        ST_POS_WAIT,
        ST_ADD,
        ST_FIX,
        ST_OUT
    } state_t;

    // request to the shared divider: (rem_init:dividend) / divisor
    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] rem_init;
        logic [LEN_W-1:0] dividend;
        logic [LEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [LEN_W-1:0] quot;
        logic [LEN_W-1:0] rem;
    } div_rsp_t;

endpackage

// File: rtl/core/lps_ram.sv
// generic single write port, single registered read port ram
module lps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    assign rdata = rd_reg;

endmodule

// File: rtl/core/lps_div.sv
// shared restoring divider, one quotient bit per cycle
module lps_div (
    input  logic              clk,
    input  logic              rst_n,
    input  lps_pkg::div_req_t req,
    output lps_pkg::div_rsp_t rsp
);

    localparam int W  = lps_pkg::LEN_W;
    localparam int CW = $clog2(W);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  q_reg, q_next;
    logic [W-1:0]  d_reg, d_next;

    logic [W:0]    r2;
    logic [W:0]    r2_sub;
    logic          ge;

    assign r2     = {r_reg, q_reg[W-1]};
    assign r2_sub = r2 - {1'b0, d_reg};
    assign ge     = (r2 >= {1'b0, d_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            r_next    = req.rem_init;
            q_next    = req.dividend;
            d_next    = req.divisor;
        end
        else if (busy_reg)
        begin
            r_next = ge ? r2_sub[W-1:0] : r2[W-1:0];
            q_next = {q_reg[W-2:0], ge};
            if (cnt_reg == CW'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        q_reg <= q_next;
        d_reg <= d_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;
    assign rsp.rem  = r_reg;

endmodule

// File: rtl/core/loop_playback_with_seek_crossfade.sv
// top level: stereo loop player with seek crossfade over a cleared sample store
// write item: written to the store as it is accepted; seek: a target beyond the loop is first wrapped by the divider
// tick: a paused tick only reports silence; a playing tick reads and advances, and a crossfade adds a divide
//   for the fade weight; each position or increment that needs wrapping adds a divider pass
// one item at a time: the shared divider, the multiplier and the single ram read port allow no overlap
// reset: asynchronous; a clearing pass over all MAX_LEN entries zeroes the store, no item taken meanwhile
module loop_playback_with_seek_crossfade #(
    parameter int MAX_LEN  = lps_pkg::DEF_MAX_LEN,
    parameter int CHANNELS = lps_pkg::DEF_CHANNELS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,    // address[15:0], left_in[31:16], right_in[47:32]
    input  logic [1:0]  s_tuser,    // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // left_out[15:0], right_out[31:16], play_position[47:32]
    input  logic        cfg_we,
    input  logic [lps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lps_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int LW = lps_pkg::LEN_W;
    localparam int PW = LW + 16;
    localparam int SW = lps_pkg::SAMPLE_W;
    localparam int XW = lps_pkg::XFADE_W;
    localparam int AW = $clog2(MAX_LEN);
    localparam int DW = SW * CHANNELS;

    function automatic logic [LW-1:0] clamp_idx(input logic [LW-1:0] pint,
                                                input logic [LW-1:0] len);
        logic [LW-1:0] lm1;
        lm1 = len - 1'b1;
        return (pint > lm1) ? lm1 : pint;
    endfunction

    // configuration
    logic [LW-1:0]                 loop_length_reg;
    logic [lps_pkg::SPEED_W-1:0]   speed_reg;
    logic                          reverse_reg;
    logic                          playing_reg;
    logic [XW-1:0]                 xfade_len_reg;

    // control and state
    lps_pkg::state_t state_reg, state_next;
    logic [AW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [PW-1:0]   play_pos_reg, play_pos_next;
    logic [PW-1:0]   src_pos_reg, src_pos_next;
    logic [XW-1:0]   fade_rem_reg, fade_rem_next;
    logic [XW-1:0]   fade_tot_reg, fade_tot_next;
    logic            adv_src_reg, adv_src_next;
    logic            out_valid_reg, out_valid_next;

    // payload
    logic [15:0]       addr_reg, addr_next;
    logic [LW-1:0]     next_int_reg, next_int_next;
    logic [SW-1:0]     dst_l_reg, dst_l_next, dst_r_reg, dst_r_next;
    logic [SW-1:0]     src_l_reg, src_l_next, src_r_reg, src_r_next;
    logic [LW-1:0]     t_reg, t_next;
    logic signed [34:0] prod_reg, prod_next;
    logic [SW-1:0]     mix_l_reg, mix_l_next, mix_r_reg, mix_r_next;
    logic [PW-1:0]     dmod_reg, dmod_next;
    logic [PW-1:0]     pmod_reg, pmod_next;
    logic [PW:0]       sum_reg, sum_next;
    logic [SW-1:0]     out_l_reg, out_l_next, out_r_reg, out_r_next;
    logic [15:0]       out_pos_reg, out_pos_next;

    // input fields
    logic [1:0]    in_cmd;
    logic [15:0]   in_addr;
    logic [SW-1:0] in_left, in_right;
    logic          s_accept;

    assign in_cmd   = s_tuser;
    assign in_addr  = s_tdata[15:0];
    assign in_left  = s_tdata[31:16];
    assign in_right = s_tdata[47:32];
    assign s_tready = (state_reg == lps_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // derived settings
    logic [LW-1:0]               eff_len;
    logic [PW-1:0]               lfix;
    logic [lps_pkg::SPEED_W-1:0] sp;
    logic [19:0]                 inc;
    logic [XW-1:0]               xfade_c;
    logic                        fade_active;
    logic [XW-1:0]               fdiff;

    always_comb
    begin
        if (loop_length_reg == '0)
        begin
            eff_len = LW'(1);
        end
        else if ({15'd0, loop_length_reg} > 32'(MAX_LEN))
        begin
            eff_len = LW'(MAX_LEN);
        end
        else
        begin
            eff_len = loop_length_reg;
        end
    end

    assign lfix = {eff_len, 16'd0};
    assign sp   = (speed_reg > lps_pkg::SPEED_MAX) ? lps_pkg::SPEED_MAX : speed_reg;
    assign inc  = {sp, 4'd0};

    always_comb
    begin
        if (xfade_len_reg < lps_pkg::XFADE_MIN)
        begin
            xfade_c = lps_pkg::XFADE_MIN;
        end
        else if (xfade_len_reg > lps_pkg::XFADE_MAX)
        begin
            xfade_c = lps_pkg::XFADE_MAX;
        end
        else
        begin
            xfade_c = xfade_len_reg;
        end
    end

    assign fade_active = (fade_rem_reg != '0) && (fade_tot_reg != '0);
    assign fdiff       = fade_tot_reg - fade_rem_reg;

    // sample store
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [DW-1:0] ram_wdata, ram_rdata;
    logic [31:0]   rd_ext;
    logic          wr_in_range;

    assign wr_in_range = ({16'd0, in_addr} < 32'(MAX_LEN));
    assign ram_we      = (state_reg == lps_pkg::ST_CLEAR) ||
                         (s_accept && (in_cmd == lps_pkg::CMD_WRITE) && wr_in_range);
    assign ram_waddr   = (state_reg == lps_pkg::ST_CLEAR) ? clr_cnt_reg : AW'(in_addr);
    assign ram_wdata   = (state_reg == lps_pkg::ST_CLEAR) ? '0 : DW'({in_right, in_left});
    assign ram_raddr   = (state_reg == lps_pkg::ST_RD_SRC) ?
                         AW'(clamp_idx(src_pos_reg[PW-1:16], eff_len)) :
                         AW'(clamp_idx(play_pos_reg[PW-1:16], eff_len));
    assign rd_ext      = 32'(ram_rdata);

    lps_ram #(
        .WIDTH(DW),
        .DEPTH(MAX_LEN)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // shared divider
    lps_pkg::div_req_t div_req;
    lps_pkg::div_rsp_t div_rsp;
    logic [PW-1:0]     cur_pos;
    logic              seek_need_div, inc_need_div, pos_need_div;

    assign cur_pos       = adv_src_reg ? src_pos_reg : play_pos_reg;
    assign seek_need_div = ({1'b0, addr_reg} >= eff_len);
    assign inc_need_div  = (LW'(inc[19:16]) >= eff_len);
    assign pos_need_div  = (cur_pos[PW-1:16] >= eff_len);

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.rem_init = '0;
        div_req.divisor  = eff_len;
        div_req.dividend = cur_pos[PW-1:16];
        unique case (state_reg)
            lps_pkg::ST_SEEK_GO:
            begin
                div_req.start    = seek_need_div;
                div_req.dividend = {1'b0, addr_reg};
            end
            lps_pkg::ST_SRC_LAT:
            begin
                // weight: (diff << 16) / total, diff split across remainder and dividend
                div_req.start    = 1'b1;
                div_req.rem_init = LW'(fdiff[XW-1:1]);
                div_req.dividend = {fdiff[0], 16'd0};
                div_req.divisor  = LW'(fade_tot_reg);
            end
            lps_pkg::ST_INC_GO:
            begin
                div_req.start    = inc_need_div;
                div_req.dividend = LW'(inc[19:16]);
            end
            lps_pkg::ST_POS_GO:
            begin
                div_req.start = pos_need_div;
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    lps_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .rsp  (div_rsp)
    );

    // shared multiplier and blend adder
    logic signed [16:0] diff_l, diff_r, mul_a;
    logic signed [34:0] mul_p;
    logic [SW-1:0]      blend_src;
    logic signed [34:0] blend_sum;

    assign diff_l    = $signed({dst_l_reg[SW-1], dst_l_reg}) - $signed({src_l_reg[SW-1], src_l_reg});
    assign diff_r    = $signed({dst_r_reg[SW-1], dst_r_reg}) - $signed({src_r_reg[SW-1], src_r_reg});
    assign mul_a     = (state_reg == lps_pkg::ST_MUL_L) ? diff_l : diff_r;
    assign mul_p     = mul_a * $signed({1'b0, t_reg});
    assign blend_src = (state_reg == lps_pkg::ST_MUL_R) ? src_l_reg : src_r_reg;
    assign blend_sum = $signed({{3{blend_src[SW-1]}}, blend_src, 16'd0}) + prod_reg;

    // seek jump and position wrap
    logic [PW-1:0] seek_pos, seek_jump, adv_res;
    logic          out_free;

    assign seek_pos  = {next_int_reg, 16'd0};
    assign seek_jump = (seek_pos > play_pos_reg) ? (seek_pos - play_pos_reg) :
                                                   (play_pos_reg - seek_pos);

    always_comb
    begin
        if (reverse_reg)
        begin
            adv_res = sum_reg[PW] ? PW'(sum_reg + {1'b0, lfix}) : sum_reg[PW-1:0];
        end
        else
        begin
            adv_res = (sum_reg >= {1'b0, lfix}) ? PW'(sum_reg - {1'b0, lfix}) :
                                                   sum_reg[PW-1:0];
        end
    end

    assign out_free = !out_valid_reg || m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lps_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == AW'(MAX_LEN - 1))
                begin
                    state_next = lps_pkg::ST_IDLE;
                end
            end
            lps_pkg::ST_IDLE:
            begin
                if (s_accept)
                begin
                    priority if (in_cmd == lps_pkg::CMD_TICK)
                    begin
                        state_next = playing_reg ? lps_pkg::ST_RD_DST : lps_pkg::ST_OUT;
                    end
                    else if (in_cmd == lps_pkg::CMD_SEEK)
                    begin
                        state_next = lps_pkg::ST_SEEK_GO;
                    end
                    else
                    begin
                        state_next = lps_pkg::ST_IDLE;
                    end
                end
            end
            lps_pkg::ST_SEEK_GO:
                state_next = seek_need_div ? lps_pkg::ST_SEEK_WAIT : lps_pkg::ST_SEEK_SET;
            lps_pkg::ST_SEEK_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = lps_pkg::ST_SEEK_SET;
                end
            end
            lps_pkg::ST_SEEK_SET:
                state_next = lps_pkg::ST_IDLE;
            lps_pkg::ST_RD_DST:
                state_next = lps_pkg::ST_RD_SRC;
            lps_pkg::ST_RD_SRC:
                state_next = fade_active ? lps_pkg::ST_SRC_LAT : lps_pkg::ST_INC_GO;
            lps_pkg::ST_SRC_LAT:
                state_next = lps_pkg::ST_T_WAIT;
            lps_pkg::ST_T_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = lps_pkg::ST_MUL_L;
                end
            end
            lps_pkg::ST_MUL_L:
                state_next = lps_pkg::ST_MUL_R;
            lps_pkg::ST_MUL_R:
                state_next = lps_pkg::ST_MIX_R;
            lps_pkg::ST_MIX_R:
                state_next = lps_pkg::ST_INC_GO;
            lps_pkg::ST_INC_GO:
                state_next = inc_need_div ? lps_pkg::ST_INC_WAIT : lps_pkg::ST_POS_GO;
            lps_pkg::ST_INC_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = lps_pkg::ST_POS_GO;
                end
            end
            lps_pkg::ST_POS_GO:
                state_next = pos_need_div ? lps_pkg::ST_POS_WAIT : lps_pkg::ST_ADD;
            lps_pkg::ST_POS_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = lps_pkg::ST_ADD;
                end
            end
            lps_pkg::ST_ADD:
                state_next = lps_pkg::ST_FIX;
            lps_pkg::ST_FIX:
                state_next = adv_src_reg ? lps_pkg::ST_POS_GO : lps_pkg::ST_OUT;
            lps_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = lps_pkg::ST_IDLE;
                end
            end
            default:
                state_next = lps_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        clr_cnt_next   = clr_cnt_reg;
        play_pos_next  = play_pos_reg;
        src_pos_next   = src_pos_reg;
        fade_rem_next  = fade_rem_reg;
        fade_tot_next  = fade_tot_reg;
        adv_src_next   = adv_src_reg;
        out_valid_next = out_valid_reg && !m_tready;
        addr_next      = addr_reg;
        next_int_next  = next_int_reg;
        dst_l_next     = dst_l_reg;
        dst_r_next     = dst_r_reg;
        src_l_next     = src_l_reg;
        src_r_next     = src_r_reg;
        t_next         = t_reg;
        prod_next      = prod_reg;
        mix_l_next     = mix_l_reg;
        mix_r_next     = mix_r_reg;
        dmod_next      = dmod_reg;
        pmod_next      = pmod_reg;
        sum_next       = sum_reg;
        out_l_next     = out_l_reg;
        out_r_next     = out_r_reg;
        out_pos_next   = out_pos_reg;
        unique case (state_reg)
            lps_pkg::ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            lps_pkg::ST_IDLE:
            begin
                if (s_accept)
                begin
                    addr_next  = in_addr;
                    // a paused tick reports silence
                    mix_l_next = '0;
                    mix_r_next = '0;
                end
            end
            lps_pkg::ST_SEEK_GO:
            begin
                next_int_next = {1'b0, addr_reg};
            end
            lps_pkg::ST_SEEK_WAIT:
            begin
                if (div_rsp.done)
                begin
                    next_int_next = div_rsp.rem;
                end
            end
            lps_pkg::ST_SEEK_SET:
            begin
                if (seek_jump > PW'(65536))
                begin
                    src_pos_next  = play_pos_reg;
                    fade_rem_next = xfade_c;
                    fade_tot_next = xfade_c;
                end
                else
                begin
                    fade_rem_next = '0;
                    fade_tot_next = '0;
                end
                play_pos_next = seek_pos;
            end
            lps_pkg::ST_RD_SRC:
            begin
                dst_l_next = rd_ext[15:0];
                dst_r_next = rd_ext[31:16];
                mix_l_next = rd_ext[15:0];
                mix_r_next = rd_ext[31:16];
            end
            lps_pkg::ST_SRC_LAT:
            begin
                src_l_next = rd_ext[15:0];
                src_r_next = rd_ext[31:16];
            end
            lps_pkg::ST_T_WAIT:
            begin
                if (div_rsp.done)
                begin
                    t_next = div_rsp.quot;
                end
            end
            lps_pkg::ST_MUL_L:
            begin
                prod_next = mul_p;
            end
            lps_pkg::ST_MUL_R:
            begin
                mix_l_next = blend_sum[31:16];
                prod_next  = mul_p;
            end
            lps_pkg::ST_MIX_R:
            begin
                mix_r_next = blend_sum[31:16];
            end
            lps_pkg::ST_INC_GO:
            begin
                dmod_next    = PW'(inc);
                adv_src_next = fade_active;
            end
            lps_pkg::ST_INC_WAIT:
            begin
                if (div_rsp.done)
                begin
                    dmod_next = {div_rsp.rem, inc[15:0]};
                end
            end
            lps_pkg::ST_POS_GO:
            begin
                pmod_next = cur_pos;
            end
            lps_pkg::ST_POS_WAIT:
            begin
                if (div_rsp.done)
                begin
                    pmod_next = {div_rsp.rem, cur_pos[15:0]};
                end
            end
            lps_pkg::ST_ADD:
            begin
                sum_next = reverse_reg ? ({1'b0, pmod_reg} - {1'b0, dmod_reg}) :
                                         ({1'b0, pmod_reg} + {1'b0, dmod_reg});
            end
            lps_pkg::ST_FIX:
            begin
                if (adv_src_reg)
                begin
                    // fade source first, then the play position
                    src_pos_next  = adv_res;
                    adv_src_next  = 1'b0;
                    fade_rem_next = fade_rem_reg - 1'b1;
                    if (fade_rem_reg == XW'(1))
                    begin
                        fade_tot_next = '0;
                    end
                end
                else
                begin
                    play_pos_next = adv_res;
                end
            end
            lps_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_l_next     = mix_l_reg;
                    out_r_next     = (CHANNELS < 2) ? '0 : mix_r_reg;
                    out_pos_next   = play_pos_reg[31:16];
                end
            end
            default:
            begin
                clr_cnt_next = clr_cnt_reg;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_length_reg <= lps_pkg::RST_LOOP_LENGTH;
            speed_reg       <= lps_pkg::RST_SPEED;
            reverse_reg     <= 1'b0;
            playing_reg     <= 1'b0;
            xfade_len_reg   <= lps_pkg::RST_XFADE_LEN;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lps_pkg::REG_LOOP_LENGTH:   loop_length_reg <= cfg_data[LW-1:0];
                lps_pkg::REG_SPEED:         speed_reg       <= cfg_data[15:0];
                lps_pkg::REG_REVERSE:       reverse_reg     <= cfg_data[0];
                lps_pkg::REG_PLAYING:       playing_reg     <= cfg_data[0];
                lps_pkg::REG_CROSSFADE_LEN: xfade_len_reg   <= cfg_data[XW-1:0];
                default:                    playing_reg     <= playing_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lps_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            play_pos_reg  <= '0;
            src_pos_reg   <= '0;
            fade_rem_reg  <= '0;
            fade_tot_reg  <= '0;
            adv_src_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            play_pos_reg  <= play_pos_next;
            src_pos_reg   <= src_pos_next;
            fade_rem_reg  <= fade_rem_next;
            fade_tot_reg  <= fade_tot_next;
            adv_src_reg   <= adv_src_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        next_int_reg <= next_int_next;
        dst_l_reg    <= dst_l_next;
        dst_r_reg    <= dst_r_next;
        src_l_reg    <= src_l_next;
        src_r_reg    <= src_r_next;
        t_reg        <= t_next;
        prod_reg     <= prod_next;
        mix_l_reg    <= mix_l_next;
        mix_r_reg    <= mix_r_next;
        dmod_reg     <= dmod_next;
        pmod_reg     <= pmod_next;
        sum_reg      <= sum_next;
        out_l_reg    <= out_l_next;
        out_r_reg    <= out_r_next;
        out_pos_reg  <= out_pos_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_pos_reg, out_r_reg, out_l_reg};

    // fade counters run and stop together
    a_fade_counters: assert property (@(posedge clk) disable iff (!rst_n)
        ((fade_rem_reg == '0) == (fade_tot_reg == '0)) && (fade_rem_reg <= fade_tot_reg))
        else $error("fade counters out of step");

    // a new result only comes from the output state
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == lps_pkg::ST_OUT))
        else $error("result raised outside the output state");

    // the play position lands inside the loop after an advance
    a_pos_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lps_pkg::ST_FIX && !adv_src_reg) |=> (play_pos_reg[PW-1:16] < eff_len))
        else $error("play position outside the loop after advance");

    // the divider only finishes while the sequencer waits for it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == lps_pkg::ST_SEEK_WAIT || state_reg == lps_pkg::ST_T_WAIT ||
                          state_reg == lps_pkg::ST_INC_WAIT || state_reg == lps_pkg::ST_POS_WAIT))
        else $error("divider finished with nobody waiting");

endmodule

// File: test/testbench.sv
// self-checking testbench for the loop playback block: frame predictor, scoreboard, stream drivers

// one output frame, laid out as on m_tdata (left_out in the lowest bits)
typedef struct packed {
    logic [15:0] position;
    logic [15:0] right;
    logic [15:0] left;
} frame_t;

class frame_scoreboard;
    logic [31:0] pair_store [0:65535];
    logic [63:0] read_pos;
    logic [63:0] fade_pos;
    int unsigned fade_left;
    int unsigned fade_len;
    logic [16:0] loop_len_reg;
    logic [15:0] speed_reg;
    bit          reverse_reg;
    bit          playing_reg;
    logic [7:0]  xfade_reg;
    frame_t      expected_frames[$];
    int          errors;
    int          frames;
    int          blended;
    int          paused_frames;

    function new();
        foreach (pair_store[i]) pair_store[i] = '0;
        read_pos      = '0;
        fade_pos      = '0;
        fade_left     = 0;
        fade_len      = 0;
        loop_len_reg  = lps_pkg::RST_LOOP_LENGTH;
        speed_reg     = lps_pkg::RST_SPEED;
        reverse_reg   = 1'b0;
        playing_reg   = 1'b0;
        xfade_reg     = lps_pkg::RST_XFADE_LEN;
        errors        = 0;
        frames        = 0;
        blended       = 0;
        paused_frames = 0;
    endfunction

    function void set_reg(logic [lps_pkg::CFG_IDX_W-1:0] idx,
                          logic [lps_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            lps_pkg::REG_LOOP_LENGTH:   loop_len_reg = val;
            lps_pkg::REG_SPEED:         speed_reg    = val[15:0];
            lps_pkg::REG_REVERSE:       reverse_reg  = val[0];
            lps_pkg::REG_PLAYING:       playing_reg  = val[0];
            lps_pkg::REG_CROSSFADE_LEN: xfade_reg    = val[7:0];
            default: ;
        endcase
    endfunction

    function logic [63:0] loop_span();
        logic [63:0] l;
        l = loop_len_reg;
        if (l < 1) l = 1;
        if (l > lps_pkg::DEF_MAX_LEN) l = lps_pkg::DEF_MAX_LEN;
        return l;
    endfunction

    function int pending();
        return expected_frames.size();
    endfunction

    // wrap-around move of a 16.16 position by one increment
    function logic [63:0] step_pos(logic [63:0] pos, logic [63:0] inc, bit back,
                                   logic [63:0] span);
        logic [63:0] p;
        logic [63:0] d;
        p = pos % span;
        d = inc % span;
        if (back) return (p >= d) ? p - d : p + span - d;
        return (p + d) % span;
    endfunction

    // a position past a shortened loop reads the last sample of the loop
    function logic [31:0] read_pair(logic [63:0] pos, logic [63:0] len);
        logic [63:0] idx;
        idx = pos >> 16;
        if (idx > len - 1) idx = len - 1;
        return pair_store[idx[15:0]];
    endfunction

    function logic [15:0] mix(logic [15:0] src, logic [15:0] dst, longint t);
        longint s;
        longint d;
        longint sum;
        s = longint'($signed(src));
        d = longint'($signed(dst));
        sum = s * (65536 - t) + d * t;
        sum = sum >>> 16;
        return sum[15:0];
    endfunction

    function void apply_item(logic [1:0] cmd, logic [15:0] addr, logic [15:0] left,
                             logic [15:0] right);
        logic [63:0] len;
        logic [63:0] span;
        logic [63:0] target;
        logic [63:0] jump;
        logic [63:0] sp;
        logic [63:0] inc;
        logic [63:0] a64;
        logic [31:0] now_pair;
        logic [31:0] old_pair;
        int unsigned xf;
        longint t;
        frame_t f;
        len  = loop_span();
        span = len << 16;
        a64  = addr;
        case (cmd)
            lps_pkg::CMD_WRITE: pair_store[addr] = {right, left};
            lps_pkg::CMD_SEEK: begin
                target = (a64 % len) << 16;
                jump = (target > read_pos) ? target - read_pos : read_pos - target;
                if (jump > 65536) begin
                    xf = xfade_reg;
                    if (xf < lps_pkg::XFADE_MIN) xf = lps_pkg::XFADE_MIN;
                    if (xf > lps_pkg::XFADE_MAX) xf = lps_pkg::XFADE_MAX;
                    fade_pos  = read_pos;
                    fade_len  = xf;
                    fade_left = xf;
                end else begin
                    fade_left = 0;
                    fade_len  = 0;
                end
                read_pos = target;
            end
            lps_pkg::CMD_TICK: begin
                f = '0;
                if (playing_reg) begin
                    sp  = (speed_reg > lps_pkg::SPEED_MAX) ? lps_pkg::SPEED_MAX : speed_reg;
                    inc = sp << 4;
                    now_pair = read_pair(read_pos, len);
                    if (fade_left > 0 && fade_len > 0) begin
                        old_pair = read_pair(fade_pos, len);
                        t = ((fade_len - fade_left) << 16) / fade_len;
                        f.left  = mix(old_pair[15:0], now_pair[15:0], t);
                        f.right = mix(old_pair[31:16], now_pair[31:16], t);
                        fade_pos = step_pos(fade_pos, inc, reverse_reg, span);
                        fade_left--;
                        if (fade_left == 0) fade_len = 0;
                        blended++;
                    end else begin
                        f.left  = now_pair[15:0];
                        f.right = now_pair[31:16];
                    end
                    read_pos = step_pos(read_pos, inc, reverse_reg, span);
                end else begin
                    paused_frames++;
                end
                f.position = read_pos[31:16];
                expected_frames.push_back(f);
            end
            default: ;  // unused code, dropped by the block
        endcase
    endfunction

    function void compare_field(string what, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            errors++;
        end
    endfunction

    function void check_frame(logic [47:0] data);
        frame_t got;
        frame_t want;
        got = data;
        if (expected_frames.size() == 0) begin
            $display("%0t: frame with none expected, actual %h", $time, data);
            errors++;
            return;
        end
        want = expected_frames.pop_front();
        frames++;
        compare_field("left_out", $signed(want.left), $signed(got.left));
        compare_field("right_out", $signed(want.right), $signed(got.right));
        compare_field("play_position", want.position, got.position);
    endfunction
endclass

module testbench;

    localparam logic [lps_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int LONG_HOLD      = 400;
    localparam int SETTLE_CYCLES  = 48;
    localparam int ITEM_TARGET    = 1100;

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [47:0]                    s_tdata;
    logic [1:0]                     s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [47:0]                    m_tdata;
    logic                           cfg_we;
    logic [lps_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [lps_pkg::CFG_DATA_W-1:0] cfg_data;

    frame_scoreboard sb;
    bit quiet;
    bit stall_long;
    int idle_cycles;
    int accepted_items;
    int settings_used;

    loop_playback_with_seek_crossfade DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [15:0] rnd16();
        return 16'($urandom);
    endfunction

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) sb.check_frame(m_tdata);
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // output side: short random stalls, one long hold-off on request
    initial begin : receiver
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_long) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                stall_long = 1'b0;
                m_tready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic [lps_pkg::CMD_W-1:0] cmd, input logic [15:0] addr,
                             input logic [15:0] left, input logic [15:0] right);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {right, left, addr};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.apply_item(cmd, addr, left, right);
        if (cmd != CMD_UNUSED) accepted_items++;
        @(negedge clk);
    endtask

    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    // wait for every frame, then let a trailing write or seek finish
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apply_settings(input logic [16:0] len, input logic [15:0] spd,
                                  input bit rev, input bit play, input logic [7:0] xf);
        logic [lps_pkg::CFG_IDX_W-1:0]  regs [5];
        logic [lps_pkg::CFG_DATA_W-1:0] vals [5];
        regs = '{lps_pkg::REG_LOOP_LENGTH, lps_pkg::REG_SPEED, lps_pkg::REG_REVERSE,
                 lps_pkg::REG_PLAYING, lps_pkg::REG_CROSSFADE_LEN};
        vals = '{len, {1'b0, spd}, {16'b0, rev}, {16'b0, play}, {9'b0, xf}};
        for (int k = 0; k < 5; k++) begin
            cfg_we    <= 1'b1;
            cfg_index <= regs[k];
            cfg_data  <= vals[k];
            @(negedge clk);
            sb.set_reg(regs[k], vals[k]);
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic directed_items();
        // reset values: paused, so silence at position zero
        send_item(lps_pkg::CMD_TICK, 16'h0000, 16'h0000, 16'h0000);
        send_item(lps_pkg::CMD_WRITE, 16'h0000, 16'h7fff, 16'h8000);
        send_item(lps_pkg::CMD_WRITE, 16'h0001, 16'h8000, 16'h7fff);
        send_item(lps_pkg::CMD_WRITE, 16'h0002, 16'hffff, 16'h0001);
        send_item(lps_pkg::CMD_WRITE, 16'hffff, 16'h1234, 16'hedcb);
        send_item(CMD_UNUSED, 16'hffff, 16'hffff, 16'hffff);
        send_item(lps_pkg::CMD_TICK, 16'hffff, 16'hffff, 16'hffff);
        drain();
        apply_settings(lps_pkg::RST_LOOP_LENGTH, lps_pkg::RST_SPEED, 1'b0, 1'b1,
                       lps_pkg::RST_XFADE_LEN);
        repeat (3) send_item(lps_pkg::CMD_TICK, 16'h0000, 16'h0000, 16'h0000);
        // one sample away: no crossfade
        send_item(lps_pkg::CMD_SEEK, 16'h0002, 16'h0000, 16'h0000);
        send_item(lps_pkg::CMD_TICK, 16'h0000, 16'h0000, 16'h0000);
        // far jump to the top of the store starts a crossfade
        send_item(lps_pkg::CMD_SEEK, 16'hffff, 16'h0000, 16'h0000);
        repeat (4) send_item(lps_pkg::CMD_TICK, 16'h0000, 16'h0000, 16'h0000);
        send_item(lps_pkg::CMD_SEEK, 16'h0000, 16'h0000, 16'h0000);
        send_item(lps_pkg::CMD_TICK, 16'h0000, 16'h0000, 16'h0000);
        send_item(CMD_UNUSED, 16'h0000, 16'h0000, 16'h0000);
        send_item(lps_pkg::CMD_TICK, 16'h0000, 16'h0000, 16'h0000);
    endtask

    task automatic run_phase(input int stop_at);
        int len;
        int kind;
        int cur;
        int ticks;
        logic [15:0] target;
        len = int'(sb.loop_span());
        // well-formed start: fill a short loop with fresh samples
        if (len <= 48) begin
            for (int k = 0; k < len; k++) begin
                sender_gap();
                send_item(lps_pkg::CMD_WRITE, 16'(k), rnd16(), rnd16());
            end
        end
        while (accepted_items < stop_at) begin
            kind = $urandom_range(0, 99);
            cur  = sb.read_pos[31:16];
            sender_gap();
            if (kind < 60) begin
                send_item(lps_pkg::CMD_TICK, rnd16(), rnd16(), rnd16());
            end else if (kind < 72) begin
                case ($urandom_range(0, 3))
                    0:       target = rnd16();
                    1:       target = 16'(cur + 1);
                    default: target = 16'($urandom_range(0, len - 1));
                endcase
                send_item(lps_pkg::CMD_SEEK, target, rnd16(), rnd16());
            end else if (kind < 86) begin
                if (len <= 48 && $urandom_range(0, 3) != 0)
                    target = 16'($urandom_range(0, len - 1));
                else target = rnd16();
                send_item(lps_pkg::CMD_WRITE, target, rnd16(), rnd16());
            end else if (kind < 94) begin
                send_item(CMD_UNUSED, rnd16(), rnd16(), rnd16());
            end else begin
                // far seek, then ticks through the whole crossfade
                target = 16'((cur + len / 2) % len);
                send_item(lps_pkg::CMD_SEEK, target, rnd16(), rnd16());
                ticks = sb.fade_left + 4;
                repeat (ticks) begin
                    sender_gap();
                    send_item(lps_pkg::CMD_TICK, rnd16(), rnd16(), rnd16());
                end
            end
        end
    endtask

    initial begin : stimulus
        int phase;
        logic [16:0] len;
        logic [15:0] spd;
        logic [7:0]  xf;
        bit rev;
        bit play;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        quiet          = 1'b0;
        stall_long     = 1'b0;
        idle_cycles    = 0;
        accepted_items = 0;
        settings_used  = 0;
        sb = new();
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        directed_items();
        phase = 0;
        while (accepted_items < ITEM_TARGET) begin
            drain();
            case (phase)
                0: begin
                    len = 17'd0; spd = 16'd0; rev = 1'b0; play = 1'b1; xf = 8'd0;
                end
                1: begin
                    len = 17'd131071; spd = 16'hffff; rev = 1'b1; play = 1'b1; xf = 8'd255;
                end
                2: begin
                    len = 17'd1; spd = lps_pkg::SPEED_MAX; rev = 1'b0; play = 1'b1;
                    xf = lps_pkg::XFADE_MIN;
                end
                3: begin
                    len = 17'd65536; spd = lps_pkg::RST_SPEED; rev = 1'b1; play = 1'b0;
                    xf = lps_pkg::XFADE_MAX;
                end
                default: begin
                    case ($urandom_range(0, 9))
                        0: begin
                            case ($urandom_range(0, 3))
                                0:       len = 17'd0;
                                1:       len = 17'd1;
                                2:       len = 17'd65536;
                                default: len = 17'd131071;
                            endcase
                        end
                        1:       len = 17'($urandom_range(49, 65536));
                        default: len = 17'($urandom_range(1, 48));
                    endcase
                    case ($urandom_range(0, 7))
                        0:       spd = 16'd0;
                        1:       spd = lps_pkg::SPEED_MAX;
                        2:       spd = 16'($urandom_range(32769, 65535));
                        3, 4, 5: spd = 16'($urandom_range(2048, 8192));
                        default: spd = 16'($urandom_range(0, 32768));
                    endcase
                    case ($urandom_range(0, 7))
                        0:       xf = 8'd0;
                        1:       xf = lps_pkg::XFADE_MIN;
                        2:       xf = lps_pkg::XFADE_MAX;
                        3:       xf = 8'd255;
                        default: xf = 8'($urandom_range(0, 255));
                    endcase
                    rev  = 1'($urandom_range(0, 1));
                    play = ($urandom_range(0, 9) != 0);
                end
            endcase
            apply_settings(len, spd, rev, play, xf);
            if (accepted_items > ITEM_TARGET - 150) quiet = 1'b1;
            // output stalled long enough for the input side to back up
            if (phase == 4) stall_long = 1'b1;
            run_phase(accepted_items + int'($urandom_range(30, 60)));
            phase++;
        end
        drain();
        $display("run covered %0d items under %0d register settings, %0d frames checked",
                 accepted_items, settings_used, sb.frames);
        $display("%0d frames blended in a crossfade, %0d frames while paused",
                 sb.blended, sb.paused_frames);
        if (sb.errors == 0 && sb.pending() == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/lps_pkg.sv
rtl/core/lps_ram.sv
rtl/core/lps_div.sv
rtl/core/loop_playback_with_seek_crossfade.sv
test/testbench.sv
